/* src/kva_pkg.sv */
// Shared types, constants and the note frequency table of the key voice allocator.
package kva_pkg;

    // Key index width; up to sixteen keys are supported.
    localparam int KEY_W  = 4;
    // Width of a frequency in hertz.
    localparam int FREQ_W = 13;
    // Width of the octave register.
    localparam int OCT_W  = 4;

    // Event codes carried on the action field.
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STOP  = 1'b1;

    // Octave range that produces sound.
    localparam logic [OCT_W-1:0] OCT_LOW  = 4'd1;
    localparam logic [OCT_W-1:0] OCT_HIGH = 4'd7;
    localparam logic [OCT_W-1:0] OCT_RESET = 4'd4;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEYS,
        ST_VOICES
    } kva_state_t;

    // One key step handed to the slot table.
    typedef struct packed {
        logic             step;
        logic             pressed;
        logic [KEY_W-1:0] idx;
    } kva_key_op_t;

    // Note frequencies of the top octave, truncated to whole hertz.
    function automatic logic [FREQ_W-1:0] kva_top_freq(input logic [KEY_W-1:0] key);
        logic [FREQ_W-1:0] freq;
        unique case (key)
            4'd0:  freq = 13'd2093;
            4'd1:  freq = 13'd2217;
            4'd2:  freq = 13'd2349;
            4'd3:  freq = 13'd2489;
            4'd4:  freq = 13'd2637;
            4'd5:  freq = 13'd2793;
            4'd6:  freq = 13'd2959;
            4'd7:  freq = 13'd3135;
            4'd8:  freq = 13'd3322;
            4'd9:  freq = 13'd3520;
            4'd10: freq = 13'd3729;
            4'd11: freq = 13'd3951;
            4'd12: freq = 13'd4186;
            4'd13: freq = 13'd4434;
            4'd14: freq = 13'd4698;
            4'd15: freq = 13'd4978;
        endcase
        return freq;
    endfunction

endpackage

/* src/key_voice_allocator_top.sv */
// Key voice allocator: one key per cycle, then one voice slot per cycle unless the output stalls.
// Keys are stepped in ST_KEYS, then voices in ST_VOICES; output words are registered.
// A new scan is accepted only in ST_IDLE, after the previous scan has visited every voice.
// Reset (asynchronous, active low): all voices free and silent, octave 4, output empty.
module key_voice_allocator_top
    import kva_pkg::*;
#(
    parameter int NUM_KEYS   = 13,
    parameter int NUM_VOICES = 4
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [OCT_W-1:0]          cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [NUM_KEYS-1:0]       keys,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [((NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1)-1:0] voice,
    output logic                      action,
    output logic [FREQ_W-1:0]         frequency,
    output logic                      sounding,
    output logic                      last
);

    localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    kva_state_t            state_reg;
    kva_state_t            state_next;
    logic [NUM_KEYS-1:0]   keys_sr_reg;
    logic [KEY_W-1:0]      key_cnt_reg;
    logic [VW-1:0]         voice_cnt_reg;
    logic [NUM_VOICES-1:0] playing_reg;
    logic [OCT_W-1:0]      octave_reg;

    logic                  out_valid_reg;
    logic [VW-1:0]         voice_reg;
    logic                  action_reg;
    logic [FREQ_W-1:0]     frequency_reg;
    logic                  sounding_reg;
    logic                  last_reg;

    kva_key_op_t           key_op;
    logic [NUM_VOICES-1:0] held;
    logic [KEY_W-1:0]      slot_key [NUM_VOICES];
    logic                  full;

    logic                  in_fire;
    logic                  keys_done;
    logic                  voices_done;
    logic                  voice_go;
    logic [NUM_VOICES-1:0] emit;
    logic [NUM_VOICES-1:0] above;
    logic                  cur_held;
    logic                  oct_ok;
    logic [2:0]            oct_shift;
    logic [FREQ_W-1:0]     start_freq;

    kva_slots #(
        .NUM_VOICES (NUM_VOICES)
    ) u_slots (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_op   (key_op),
        .held     (held),
        .slot_key (slot_key),
        .full     (full)
    );

    // Step conditions of the sequencer.
    assign in_fire     = in_valid && in_ready;
    assign keys_done   = key_cnt_reg == KEY_W'(NUM_KEYS - 1);
    assign voices_done = voice_cnt_reg == VW'(NUM_VOICES - 1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_KEYS;
                end
            end
            ST_KEYS:
            begin
                if (keys_done)
                begin
                    state_next = ST_VOICES;
                end
            end
            ST_VOICES:
            begin
                if (voice_go && voices_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: input handshake, key step and voice step.
    always_comb
    begin
        in_ready       = state_reg == ST_IDLE;
        key_op.step    = state_reg == ST_KEYS;
        key_op.pressed = keys_sr_reg[0];
        key_op.idx     = key_cnt_reg;
        voice_go       = (state_reg == ST_VOICES) && (!out_valid_reg || out_ready);
    end

    // A voice emits when its held state differs from its playing state.
    always_comb
    begin
        emit = held ^ playing_reg;
        for (int i = 0; i < NUM_VOICES; i++)
        begin
            above[i] = VW'(i) > voice_cnt_reg;
        end
    end

    // Start frequency: top octave entry shifted down to the selected octave.
    always_comb
    begin
        cur_held   = held[voice_cnt_reg];
        oct_ok     = (octave_reg >= OCT_LOW) && (octave_reg <= OCT_HIGH);
        oct_shift  = 3'(OCT_HIGH - octave_reg);
        start_freq = oct_ok ? (kva_top_freq(slot_key[voice_cnt_reg]) >> oct_shift) : '0;
    end

    // Sequencer control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            key_cnt_reg   <= '0;
            voice_cnt_reg <= '0;
            playing_reg   <= '0;
            octave_reg    <= OCT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                octave_reg <= cfg_wr_data;
            end
            if (in_fire)
            begin
                key_cnt_reg <= '0;
            end
            else if (key_op.step)
            begin
                key_cnt_reg <= keys_done ? '0 : key_cnt_reg + KEY_W'(1);
            end
            if (voice_go)
            begin
                voice_cnt_reg              <= voices_done ? '0 : voice_cnt_reg + VW'(1);
                playing_reg[voice_cnt_reg] <= cur_held;
            end
        end
    end

    // Key bits are consumed one per cycle, lowest key first.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            keys_sr_reg <= keys;
        end
        else if (key_op.step)
        begin
            keys_sr_reg <= keys_sr_reg >> 1;
        end
    end

    // Output word valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (voice_go && emit[voice_cnt_reg])
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output word payload: start for a newly held voice, stop for a freed one.
    always_ff @(posedge clk)
    begin
        if (voice_go && emit[voice_cnt_reg])
        begin
            voice_reg     <= voice_cnt_reg;
            action_reg    <= cur_held ? ACT_START : ACT_STOP;
            frequency_reg <= cur_held ? start_freq : '0;
            sounding_reg  <= cur_held && oct_ok && !full;
            last_reg      <= !(|(emit & above));
        end
    end

    assign out_valid = out_valid_reg;
    assign voice     = voice_reg;
    assign action    = action_reg;
    assign frequency = frequency_reg;
    assign sounding  = sounding_reg;
    assign last      = last_reg;

endmodule

/* src/kva_slots.sv */
// Voice slot table: which key holds each voice, and how many voices are held.
module kva_slots
    import kva_pkg::*;
#(
    parameter int NUM_VOICES = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  kva_key_op_t           key_op,
    output logic [NUM_VOICES-1:0] held,
    output logic [KEY_W-1:0]      slot_key [NUM_VOICES],
    output logic                  full
);

    localparam int CNT_W = $clog2(NUM_VOICES + 1);

    logic [NUM_VOICES-1:0] held_reg;
    logic [NUM_VOICES-1:0] held_next;
    logic [KEY_W-1:0]      key_reg [NUM_VOICES];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    logic [NUM_VOICES-1:0] match;
    logic [NUM_VOICES-1:0] free_mask;
    logic [NUM_VOICES-1:0] first_free;
    logic                  can_take;
    logic                  take;
    logic                  drop;

    // Find the slot already held by this key and the lowest free slot.
    always_comb
    begin
        for (int v = 0; v < NUM_VOICES; v++)
        begin
            match[v] = held_reg[v] && (key_reg[v] == key_op.idx);
        end
        free_mask  = ~held_reg;
        first_free = free_mask & (~free_mask + NUM_VOICES'(1));
        can_take   = count_reg < CNT_W'(NUM_VOICES);
        take       = key_op.step && key_op.pressed && !(|match) && can_take;
        drop       = key_op.step && !key_op.pressed && (|match);
    end

    // A pressed key takes the lowest free slot; a released key frees its slot.
    always_comb
    begin
        held_next  = held_reg;
        count_next = count_reg;
        if (take)
        begin
            held_next  = held_reg | first_free;
            count_next = count_reg + CNT_W'(1);
        end
        else if (drop)
        begin
            held_next  = held_reg & ~match;
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Control state of the table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            held_reg  <= held_next;
            count_reg <= count_next;
        end
    end

    // Key numbers are only meaningful while the slot is held.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < NUM_VOICES; v++)
            begin
                key_reg[v] <= '0;
            end
        end
        else
        begin
            for (int v = 0; v < NUM_VOICES; v++)
            begin
                if (take && first_free[v])
                begin
                    key_reg[v] <= key_op.idx;
                end
            end
        end
    end

    assign held     = held_reg;
    assign slot_key = key_reg;
    assign full     = !can_take;

endmodule

/* src/kva_checker.sv */
// Port-level checks of the key voice allocator, bound to the top level.
module kva_checker
    import kva_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              action,
    input logic [FREQ_W-1:0] frequency,
    input logic              sounding
);

    // A word that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("output word dropped before it was taken");

    // Only a start word can drive a tone.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sounding |-> action == ACT_START)
    else $error("stop word marked as sounding");

    // A stop word carries no frequency.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == ACT_STOP) |-> frequency == '0)
    else $error("stop word carries a frequency");

    // After a scan is taken the block is busy working on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("new scan accepted while the previous one is in progress");

endmodule

bind key_voice_allocator_top kva_checker u_kva_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .action    (action),
    .frequency (frequency),
    .sounding  (sounding)
);
